FILE: src/base64_stream_encoder_assert.svh
// Assertion macros shared by the encoder's checker.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define B64SE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b64se check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define B64SE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("b64se check failed");

`endif

FILE: src/b64se_pkg.sv
// Types, constants and the symbol map of the base64url stream encoder.
package b64se_pkg;

	// Padding character '='
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Alphabet anchors
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;

	// Reset values of the two configurable symbols ('-' and '_')
	localparam logic [7:0] SYM62_RESET = 8'h2D;
	localparam logic [7:0] SYM63_RESET = 8'h5F;

	// Configuration register indexes
	localparam logic CFG_SYMBOL_62 = 1'b0;
	localparam logic CFG_SYMBOL_63 = 1'b1;

	// One encoded group: four characters (index 0 goes out first) and the end mark
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic            is_last;
	} grp_t;

	// Map a 6-bit value to its character
	function automatic logic [7:0] map_sym(input logic [5:0] v, input logic [7:0] s62,
		input logic [7:0] s63);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = CHAR_UPPER_A + {2'b00, v};
		end else if (v < 6'd52) begin
			r = CHAR_LOWER_A + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			r = CHAR_DIGIT_0 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			r = s62;
		end else begin
			r = s63;
		end
		return r;
	endfunction

endpackage

FILE: src/b64se_pack.sv
// Group builder: splits up to three bytes into four mapped characters with padding.
module b64se_pack (
	input  logic [7:0]      data_byte,
	input  logic            last_byte,
	input  logic [7:0]      pend0,
	input  logic [7:0]      pend1,
	input  logic [1:0]      pend_cnt,
	input  logic [7:0]      sym62,
	input  logic [7:0]      sym63,
	output b64se_pkg::grp_t grp
);

	logic [7:0]      b0, b1, b2;
	logic [3:0][5:0] v;
	logic [3:0]      pad;

	// Byte selection: a partial group is zero filled
	always_comb begin
		case (pend_cnt)
			2'd1: begin
				b0 = pend0;
				b1 = data_byte;
				b2 = 8'h00;
			end
			2'd2: begin
				b0 = pend0;
				b1 = pend1;
				b2 = data_byte;
			end
			default: begin
				b0 = data_byte;
				b1 = 8'h00;
				b2 = 8'h00;
			end
		endcase
	end

	// Split 24 bits into four sextets, most significant first
	assign v[0] = b0[7:2];
	assign v[1] = {b0[1:0], b1[7:4]};
	assign v[2] = {b1[3:0], b2[7:6]};
	assign v[3] = b2[5:0];

	// One byte gives two symbols, two bytes give three
	assign pad[0] = 1'b0;
	assign pad[1] = 1'b0;
	assign pad[2] = (pend_cnt != 2'd1) && (pend_cnt != 2'd2);
	assign pad[3] = (pend_cnt != 2'd2);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			grp.chars[k] = pad[k] ? b64se_pkg::PAD_CHAR
				: b64se_pkg::map_sym(v[k], sym62, sym63);
		end
		grp.is_last = last_byte;
	end

endmodule

FILE: src/base64_stream_encoder.sv
// Top level of the base64url stream encoder with '=' padding.
//
// Input channel: in_valid / in_stall carry data_byte and last_byte, one raw
// byte per transfer; last_byte marks the final byte of a message.
// Output channel: out_valid / out_stall carry out_char and out_last, one
// ASCII character per transfer; out_last marks the final character.
// Every third byte, and every last byte, builds a group of four characters
// in the group register; the output register then sends them one per cycle.
// The byte that completes a group loads it into the group register, from
// which its first character moves on into the output register. Throughput
// is one character per cycle while the receiver does not stall, set by the
// single output register; bytes that only fill the pending buffer are
// taken every cycle. A byte that completes a group is stalled while the
// previous group still has characters left beyond the current cycle.
// When the receiver stalls, the output register holds its character and
// the group register holds the rest; input keeps flowing until a group
// needs the group register.
// Reset clears the pending count, empties both registers and restores the
// configurable symbols to '-' and '_'. Configuration: cfg_we, cfg_index
// (0 = symbol 62, 1 = symbol 63), cfg_data; write only while idle.
module base64_stream_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       out_last
);

	logic [7:0]      sym62_q, sym63_q;
	logic [7:0]      pend_q [2];
	logic [1:0]      pend_cnt_q;
	b64se_pkg::grp_t grp_new, grp_q;
	logic            grp_valid_q;
	logic [1:0]      grp_idx_q;
	logic            out_valid_q;
	logic [7:0]      out_char_q;
	logic            out_last_q;

	logic in_xfer, makes_grp, grp_load, out_load, grp_release;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym62_q <= b64se_pkg::SYM62_RESET;
			sym63_q <= b64se_pkg::SYM63_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				b64se_pkg::CFG_SYMBOL_62: sym62_q <= cfg_data;
				b64se_pkg::CFG_SYMBOL_63: sym63_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake and group control
	assign makes_grp   = last_byte || (pend_cnt_q == 2'd2);
	assign out_load    = grp_valid_q && (!out_valid_q || !out_stall);
	assign grp_release = out_load && (grp_idx_q == 2'd3);
	assign in_stall    = grp_valid_q && !grp_release && makes_grp;
	assign in_xfer     = in_valid && !in_stall;
	assign grp_load    = in_xfer && makes_grp;

	b64se_pack u_pack (
		.data_byte (data_byte),
		.last_byte (last_byte),
		.pend0     (pend_q[0]),
		.pend1     (pend_q[1]),
		.pend_cnt  (pend_cnt_q),
		.sym62     (sym62_q),
		.sym63     (sym63_q),
		.grp       (grp_new)
	);

	// Pending count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= 2'd0;
		end else if (in_xfer) begin
			pend_cnt_q <= makes_grp ? 2'd0 : pend_cnt_q + 2'd1;
		end
	end

	// Pending bytes
	always_ff @(posedge clk) begin
		if (in_xfer && !makes_grp) begin
			pend_q[pend_cnt_q[0]] <= data_byte;
		end
	end

	// Group register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			grp_idx_q   <= 2'd0;
		end else if (grp_load) begin
			grp_valid_q <= 1'b1;
			grp_idx_q   <= 2'd0;
		end else begin
			if (grp_release) begin
				grp_valid_q <= 1'b0;
			end
			if (out_load) begin
				grp_idx_q <= grp_idx_q + 2'd1;
			end
		end
	end

	// Group payload
	always_ff @(posedge clk) begin
		if (grp_load) begin
			grp_q <= grp_new;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q <= grp_q.chars[grp_idx_q];
			out_last_q <= grp_q.is_last && (grp_idx_q == 2'd3);
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

FILE: src/b64se_checker.sv
// Port-level checker for the base64url stream encoder, with its bind.
`include "base64_stream_encoder_assert.svh"

module b64se_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       last_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_char,
	input logic       out_last
);

	logic       in_xfer, out_xfer, grp_done;
	logic [1:0] pos_q;
	logic [1:0] char_pos_q;
	logic [3:0] owed_q;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign grp_done = in_xfer && (last_byte || (pos_q == 2'd2));

	// Byte position within the current group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (in_xfer) begin
			pos_q <= grp_done ? 2'd0 : pos_q + 2'd1;
		end
	end

	// Character position within the current group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_pos_q <= 2'd0;
		end else if (out_xfer) begin
			char_pos_q <= char_pos_q + 2'd1;
		end
	end

	// Characters owed: four per completed group, one less per output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= 4'd0;
		end else begin
			owed_q <= owed_q + (grp_done ? 4'd4 : 4'd0) - (out_xfer ? 4'd1 : 4'd0);
		end
	end

	// A stalled character holds
	`B64SE_ASSERT_NXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(out_char) && $stable(out_last))
	// The end mark closes a group of four
	`B64SE_ASSERT_IMP(a_last_aligned, out_xfer && out_last, char_pos_q == 2'd3)
	// No character without a group behind it
	`B64SE_ASSERT_IMP(a_no_phantom, out_valid, owed_q != 4'd0)
	// At most one group plus the output register in flight
	`B64SE_ASSERT_IMP(a_owed_bound, 1'b1, owed_q <= 4'd5)

endmodule

bind base64_stream_encoder b64se_checker u_b64se_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.last_byte (last_byte),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_char  (out_char),
	.out_last  (out_last)
);
